[rtl/motion_and_pulse_conditioning_defines.svh]
// Assertion macros for the checker file of the conditioning block.
// No dependencies.
`ifndef MOTION_AND_PULSE_CONDITIONING_DEFINES_SVH
`define MOTION_AND_PULSE_CONDITIONING_DEFINES_SVH

// Clocked assertion, off while reset is high
`define MPC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked around reset
`define MPC_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/mpc_pkg.sv]
// Types and constants of the motion and pulse conditioning block.
// No dependencies; used by every other file but the defines header.
package mpc_pkg;

   localparam int PEAK_LIMIT = 5;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_FILTER_ALPHA = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RATE_MIN = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_RATE_MAX = 2'd2;

   localparam logic [15:0] ALPHA_RESET = 16'd13107;
   localparam logic [7:0] RATE_MIN_RESET = 8'd40;
   localparam logic [7:0] RATE_MAX_RESET = 8'd200;
   localparam logic [16:0] DECAY_Q16 = 17'd58982;
   localparam logic [25:0] USEC_PER_MIN = 26'd60000000;

   localparam int MUL_A_W = 37;
   localparam int MUL_B_W = 18;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   typedef struct packed {
      logic [47:0] time_us;
      logic signed [15:0] acc_x;
      logic signed [15:0] acc_y;
      logic signed [15:0] acc_z;
      logic signed [15:0] rot_x;
      logic signed [15:0] rot_y;
      logic signed [15:0] rot_z;
      logic pulse_present;
      logic [17:0] ir_sample;
   } req_data_type;

   typedef struct packed {
      logic signed [15:0] fil_acc_x;
      logic signed [15:0] fil_acc_y;
      logic signed [15:0] fil_acc_z;
      logic signed [15:0] fil_rot_x;
      logic signed [15:0] fil_rot_y;
      logic signed [15:0] fil_rot_z;
      logic [15:0] acc_magnitude;
      logic [19:0] activity;
      logic [7:0] beat_rate;
      logic beat_rate_valid;
      logic [47:0] time_out;
   } rsp_data_type;

   // Status of an iterative unit
   typedef struct packed {
      logic busy;
   } unit_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILT_MUL,
      ST_FILT_ACC,
      ST_SQ_MUL,
      ST_SQ_ACC,
      ST_SQRT_START,
      ST_SQRT_WAIT,
      ST_DEC_MUL,
      ST_DEC_ACC,
      ST_PULSE,
      ST_OUT
   } state_type;

endpackage

[rtl/mpc_req_if.sv]
// Input item channel of the conditioning block.
// Depends on mpc_pkg.
interface mpc_req_if;
   logic valid;
   logic ready;
   mpc_pkg::req_data_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[rtl/mpc_rsp_if.sv]
// Result item channel of the conditioning block.
// Depends on mpc_pkg.
interface mpc_rsp_if;
   logic valid;
   logic ready;
   mpc_pkg::rsp_data_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[rtl/mpc_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on mpc_pkg.
module mpc_mul (
   input  logic clock,
   input  logic signed [mpc_pkg::MUL_A_W-1:0] a,
   input  logic signed [mpc_pkg::MUL_B_W-1:0] b,
   output logic signed [mpc_pkg::MUL_P_W-1:0] p
);
   logic signed [mpc_pkg::MUL_P_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= a * b;
   end

   assign p = prod_ff;
endmodule

[rtl/mpc_isqrt.sv]
// Bit-pair integer square root of a 32-bit value, one result bit a cycle.
// Depends on mpc_pkg.
module mpc_isqrt (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [31:0] value,
   output logic [15:0] root,
   output mpc_pkg::unit_status_type status
);
   logic [31:0] rem_ff;
   logic [31:0] root_ff;
   logic [31:0] bit_ff;
   logic [3:0] iter_ff;
   logic busy_ff;
   logic [32:0] trial;

   assign trial = {1'b0, root_ff} + {1'b0, bit_ff};

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         iter_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         iter_ff <= 4'd15;
      end else if (busy_ff) begin
         iter_ff <= iter_ff - 4'd1;
         if (iter_ff == 4'd0) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // one step per cycle
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= value;
         root_ff <= '0;
         bit_ff <= 32'h4000_0000;
      end else if (busy_ff) begin
         if ({1'b0, rem_ff} >= trial) begin
            rem_ff <= rem_ff - trial[31:0];
            root_ff <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign root = root_ff[15:0];
   assign status.busy = busy_ff;
endmodule

[rtl/mpc_div.sv]
// Restoring divider: 60000000 / interval, one quotient bit a cycle.
// Depends on mpc_pkg.
module mpc_div (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [47:0] divisor,
   output logic [25:0] quotient,
   output mpc_pkg::unit_status_type status
);
   logic [48:0] rem_ff;
   logic [25:0] quo_ff;
   logic [47:0] dvs_ff;
   logic [4:0] iter_ff;
   logic busy_ff;
   logic [48:0] shifted;

   assign shifted = {rem_ff[47:0], quo_ff[25]};

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         iter_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         iter_ff <= 5'd25;
      end else if (busy_ff) begin
         iter_ff <= iter_ff - 5'd1;
         if (iter_ff == 5'd0) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // dividend bits shift out of the quotient register, quotient bits in
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= mpc_pkg::USEC_PER_MIN;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_ff <= shifted - {1'b0, dvs_ff};
            quo_ff <= {quo_ff[24:0], 1'b1};
         end else begin
            rem_ff <= shifted;
            quo_ff <= {quo_ff[24:0], 1'b0};
         end
      end
   end

   assign quotient = quo_ff;
   assign status.busy = busy_ff;
endmodule

[rtl/motion_and_pulse_conditioning.sv]
// Motion and pulse conditioning block.
//
// req_chan (sink) takes one item: time stamp, three acceleration and three
// angular-rate samples and an optional infrared pulse reading. rsp_chan
// (source) returns exactly one result item per input item: six low-pass
// filtered channels, the acceleration magnitude, the activity level, the
// smoothed beat rate with its valid flag and the time stamp.
// csr_we/csr_index/csr_wdata write filter_alpha (0), rate_min_bpm (1) and
// rate_max_bpm (2); other indexes are ignored.
// One shared multiplier runs six filter updates and three squares (a
// multiply and an accumulate state each), then a start state, the wait
// on the 16-step square root, the activity decay (multiply and
// accumulate), the pulse state waiting on the divider, and the output
// state. The 26-step beat interval divider runs alongside. req_chan.ready
// is high only while idle, so a new item waits until the result is loaded.
// A finished result waits in the output register while the receiver
// stalls; the block holds in its last state until that register is free.
// Reset (synchronous, active high) clears all filter and pulse state and
// loads the register defaults; no clearing pass is needed.
// Depends on mpc_pkg, mpc_req_if, mpc_rsp_if, mpc_mul, mpc_isqrt, mpc_div.
module motion_and_pulse_conditioning (
   input  logic clock,
   input  logic reset,
   mpc_req_if.sink req_chan,
   mpc_rsp_if.source rsp_chan,
   input  logic csr_we,
   input  logic [mpc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mpc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   mpc_pkg::state_type state_ff, state_in;

   logic [15:0] alpha_ff;
   logic [7:0] rate_min_ff;
   logic [7:0] rate_max_ff;

   mpc_pkg::req_data_type item_ff;
   logic signed [31:0] filt_ff [6];
   logic signed [15:0] cnt_ff [6];
   logic [2:0] ch_ff;
   logic [31:0] sumsq_ff;
   logic [35:0] decayed_ff;
   logic [15:0] prev_mag_ff;
   logic [15:0] mag_ff;
   logic [35:0] act_ff;
   logic [17:0] prev_ir_ff;
   logic [7:0] rate_ff;
   logic [2:0] count_ff;
   logic [47:0] last_peak_ff;

   logic rsp_valid_ff;
   mpc_pkg::rsp_data_type rsp_data_ff;

   logic accept;
   logic rsp_load;
   logic sqrt_start;
   logic signed [mpc_pkg::MUL_A_W-1:0] mul_a;
   logic signed [mpc_pkg::MUL_B_W-1:0] mul_b;
   logic signed [mpc_pkg::MUL_P_W-1:0] mul_p;

   logic [15:0] sqrt_root;
   mpc_pkg::unit_status_type sqrt_stat;
   logic [25:0] div_q;
   mpc_pkg::unit_status_type div_stat;

   logic signed [15:0] sample;
   logic signed [31:0] filt_cur;
   logic signed [33:0] filt_diff;
   logic signed [mpc_pkg::MUL_P_W-1:0] mix_sh;
   logic signed [31:0] filt_new;
   logic signed [32:0] round_sum;
   logic signed [16:0] counts;
   logic signed [15:0] counts_sat;
   logic [15:0] mag_delta;
   logic [36:0] act_sum;
   logic peak;
   logic attempt;
   logic rate_ok;
   logic [9:0] rate_mix;

   assign accept = req_chan.valid && req_chan.ready;

   mpc_mul u_mul (.clock(clock), .a(mul_a), .b(mul_b), .p(mul_p));

   mpc_isqrt u_isqrt (
      .clock(clock), .reset(reset), .start(sqrt_start), .value(sumsq_ff),
      .root(sqrt_root), .status(sqrt_stat)
   );

   mpc_div u_div (
      .clock(clock), .reset(reset), .start(accept),
      .divisor(req_chan.data.time_us - last_peak_ff),
      .quotient(div_q), .status(div_stat)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= mpc_pkg::ALPHA_RESET;
         rate_min_ff <= mpc_pkg::RATE_MIN_RESET;
         rate_max_ff <= mpc_pkg::RATE_MAX_RESET;
      end else if (csr_we) begin
         case (csr_index)
            mpc_pkg::REG_FILTER_ALPHA: alpha_ff <= csr_wdata;
            mpc_pkg::REG_RATE_MIN: rate_min_ff <= csr_wdata[7:0];
            mpc_pkg::REG_RATE_MAX: rate_max_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // sample of the current channel
   always_comb begin
      case (ch_ff)
         3'd0: sample = item_ff.acc_x;
         3'd1: sample = item_ff.acc_y;
         3'd2: sample = item_ff.acc_z;
         3'd3: sample = item_ff.rot_x;
         3'd4: sample = item_ff.rot_y;
         3'd5: sample = item_ff.rot_z;
         default: sample = '0;
      endcase
   end

   // filter arithmetic: f' = f + floor(alpha * ((x << 16) - f) / 65536)
   assign filt_cur = filt_ff[ch_ff];
   assign filt_diff = {{2{sample[15]}}, sample, 16'd0} - {{2{filt_cur[31]}}, filt_cur};
   assign mix_sh = mul_p >>> 16;
   assign filt_new = filt_cur + mix_sh[31:0];
   assign round_sum = {filt_new[31], filt_new} + 33'sd32768;
   assign counts = round_sum[32:16];
   assign counts_sat = (counts > 17'sd32767) ? 16'sh7fff :
                       (counts < -17'sd32768) ? 16'sh8000 : counts[15:0];

   // activity update
   assign mag_delta = (mag_ff >= prev_mag_ff) ? mag_ff - prev_mag_ff : prev_mag_ff - mag_ff;
   assign act_sum = {1'b0, decayed_ff} + {5'd0, mag_delta, 16'd0};

   // beat rate decision
   assign peak = item_ff.pulse_present && (item_ff.ir_sample < prev_ir_ff) &&
                 (prev_ir_ff != '0);
   assign attempt = peak && (last_peak_ff != '0) &&
                    (count_ff < 3'(mpc_pkg::PEAK_LIMIT)) &&
                    (item_ff.time_us > last_peak_ff);
   assign rate_ok = (div_q >= {18'd0, rate_min_ff}) && (div_q <= {18'd0, rate_max_ff});
   assign rate_mix = ({2'd0, rate_ff} * 10'd3 + {2'd0, div_q[7:0]}) >> 2;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mpc_pkg::ST_IDLE: if (accept) state_in = mpc_pkg::ST_FILT_MUL;
         mpc_pkg::ST_FILT_MUL: state_in = mpc_pkg::ST_FILT_ACC;
         mpc_pkg::ST_FILT_ACC: begin
            state_in = (ch_ff == 3'd5) ? mpc_pkg::ST_SQ_MUL : mpc_pkg::ST_FILT_MUL;
         end
         mpc_pkg::ST_SQ_MUL: state_in = mpc_pkg::ST_SQ_ACC;
         mpc_pkg::ST_SQ_ACC: begin
            state_in = (ch_ff == 3'd2) ? mpc_pkg::ST_SQRT_START : mpc_pkg::ST_SQ_MUL;
         end
         mpc_pkg::ST_SQRT_START: state_in = mpc_pkg::ST_SQRT_WAIT;
         mpc_pkg::ST_SQRT_WAIT: if (!sqrt_stat.busy) state_in = mpc_pkg::ST_DEC_MUL;
         mpc_pkg::ST_DEC_MUL: state_in = mpc_pkg::ST_DEC_ACC;
         mpc_pkg::ST_DEC_ACC: state_in = mpc_pkg::ST_PULSE;
         mpc_pkg::ST_PULSE: if (!div_stat.busy) state_in = mpc_pkg::ST_OUT;
         mpc_pkg::ST_OUT: if (rsp_load) state_in = mpc_pkg::ST_IDLE;
         default: state_in = mpc_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_chan.ready = 1'b0;
      sqrt_start = 1'b0;
      rsp_load = 1'b0;
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         mpc_pkg::ST_IDLE: req_chan.ready = 1'b1;
         mpc_pkg::ST_FILT_MUL: begin
            mul_a = {{3{filt_diff[33]}}, filt_diff};
            mul_b = {2'b00, alpha_ff};
         end
         mpc_pkg::ST_SQ_MUL: begin
            mul_a = {{21{cnt_ff[ch_ff][15]}}, cnt_ff[ch_ff]};
            mul_b = {{2{cnt_ff[ch_ff][15]}}, cnt_ff[ch_ff]};
         end
         mpc_pkg::ST_SQRT_START: sqrt_start = 1'b1;
         mpc_pkg::ST_DEC_MUL: begin
            mul_a = {1'b0, act_ff};
            mul_b = {1'b0, mpc_pkg::DECAY_Q16};
         end
         mpc_pkg::ST_OUT: rsp_load = !rsp_valid_ff || rsp_chan.ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= mpc_pkg::ST_IDLE;
      else state_ff <= state_in;
   end

   // channel counter
   always_ff @(posedge clock) begin
      if (reset) begin
         ch_ff <= '0;
      end else if ((state_ff == mpc_pkg::ST_FILT_ACC && ch_ff == 3'd5) ||
                   (state_ff == mpc_pkg::ST_SQ_ACC && ch_ff == 3'd2)) begin
         ch_ff <= '0;
      end else if (state_ff == mpc_pkg::ST_FILT_ACC || state_ff == mpc_pkg::ST_SQ_ACC) begin
         ch_ff <= ch_ff + 3'd1;
      end
   end

   // input item and scratch values
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_chan.data;
         sumsq_ff <= '0;
      end
      if (state_ff == mpc_pkg::ST_SQ_ACC) begin
         sumsq_ff <= sumsq_ff + mul_p[31:0];
      end
      if (state_ff == mpc_pkg::ST_FILT_ACC) begin
         cnt_ff[ch_ff] <= counts_sat;
      end
      if (state_ff == mpc_pkg::ST_SQRT_WAIT) begin
         mag_ff <= sqrt_root;
      end
      if (state_ff == mpc_pkg::ST_DEC_ACC) begin
         decayed_ff <= mul_p[51:16];
      end
   end

   // persistent filter and pulse state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) filt_ff[i] <= '0;
         prev_mag_ff <= '0;
         act_ff <= '0;
         prev_ir_ff <= '0;
         rate_ff <= '0;
         count_ff <= '0;
         last_peak_ff <= '0;
      end else begin
         if (state_ff == mpc_pkg::ST_FILT_ACC) begin
            filt_ff[ch_ff] <= filt_new;
         end
         // decayed value is registered in DEC_ACC, before PULSE
         if (state_ff == mpc_pkg::ST_PULSE && !div_stat.busy) begin
            prev_mag_ff <= mag_ff;
            act_ff <= act_sum[36] ? 36'hf_ffff_ffff : act_sum[35:0];
            if (item_ff.pulse_present) begin
               prev_ir_ff <= item_ff.ir_sample;
               if (peak) last_peak_ff <= item_ff.time_us;
               if (attempt && rate_ok) begin
                  rate_ff <= rate_mix[7:0];
                  count_ff <= count_ff + 3'd1;
               end
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.fil_acc_x <= cnt_ff[0];
         rsp_data_ff.fil_acc_y <= cnt_ff[1];
         rsp_data_ff.fil_acc_z <= cnt_ff[2];
         rsp_data_ff.fil_rot_x <= cnt_ff[3];
         rsp_data_ff.fil_rot_y <= cnt_ff[4];
         rsp_data_ff.fil_rot_z <= cnt_ff[5];
         rsp_data_ff.acc_magnitude <= mag_ff;
         rsp_data_ff.activity <= act_ff[35:16];
         rsp_data_ff.beat_rate <= item_ff.pulse_present ? rate_ff : 8'd0;
         rsp_data_ff.beat_rate_valid <= item_ff.pulse_present && (count_ff >= 3'd3);
         rsp_data_ff.time_out <= item_ff.time_us;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data = rsp_data_ff;
endmodule

[rtl/mpc_checker.sv]
// Port-level checks of the conditioning block, bound to its top level.
// Depends on mpc_pkg and motion_and_pulse_conditioning_defines.svh.
`include "motion_and_pulse_conditioning_defines.svh"

module mpc_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input mpc_pkg::rsp_data_type rsp_data
);
   // a waiting result stays until taken
   `MPC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result item dropped")
   // a stalled result keeps its payload
   `MPC_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_data), "result item changed while stalled")
   // one item at a time: busy right after an accept
   `MPC_ASSERT(a_busy, clock, reset, req_valid && req_ready |=> !req_ready, "item accepted while busy")
   // reset leaves the block idle and empty
   `MPC_ASSERT_NR(a_reset, clock, reset |=> !rsp_valid && req_ready, "not idle after reset")
endmodule

bind motion_and_pulse_conditioning mpc_checker u_mpc_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_data(rsp_chan.data)
);

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for motion_and_pulse_conditioning: random inertial and pulse items,
// a scoreboard class predicting every result. Depends on mpc_pkg, mpc_req_if, mpc_rsp_if.
module tb_top;

   // Predicts results from the accepted input items and checks the block's output
   class conditioning_scoreboard;
      longint acc_state[3];
      longint rot_state[3];
      longint unsigned prev_mag;
      longint unsigned activity_q16;
      longint unsigned prev_ir;
      longint unsigned rate;
      int unsigned rate_count;
      longint unsigned last_peak;
      longint unsigned alpha;
      longint unsigned rate_lo;
      longint unsigned rate_hi;
      mpc_pkg::rsp_data_type expected_q[$];
      int errors;
      int checked;
      int peaks;

      function new();
         for (int i = 0; i < 3; i++) begin
            acc_state[i] = 0;
            rot_state[i] = 0;
         end
         prev_mag = 0;
         activity_q16 = 0;
         prev_ir = 0;
         rate = 0;
         rate_count = 0;
         last_peak = 0;
         alpha = 64'(mpc_pkg::ALPHA_RESET);
         rate_lo = 64'(mpc_pkg::RATE_MIN_RESET);
         rate_hi = 64'(mpc_pkg::RATE_MAX_RESET);
         errors = 0;
         checked = 0;
         peaks = 0;
      endfunction

      function void write_reg(logic [mpc_pkg::CSR_INDEX_W-1:0] idx,
                              logic [mpc_pkg::CSR_DATA_W-1:0] val);
         case (idx)
            mpc_pkg::REG_FILTER_ALPHA: alpha = 64'(val);
            mpc_pkg::REG_RATE_MIN: rate_lo = 64'(val[7:0]);
            mpc_pkg::REG_RATE_MAX: rate_hi = 64'(val[7:0]);
            default: ;
         endcase
      endfunction

      // first-order low-pass on Q16.16 state
      function longint lowpass(longint st, longint x);
         longint a;
         a = alpha;
         return (a * (x <<< 16) + (65536 - a) * st) >>> 16;
      endfunction

      function longint counts(longint st);
         longint c;
         c = (st + 32768) >>> 16;
         if (c > 32767) c = 32767;
         if (c < -32768) c = -32768;
         return c;
      endfunction

      function longint unsigned sqrt_floor(longint unsigned v);
         longint unsigned root, bitv;
         root = 0;
         bitv = 64'd1 << 32;
         while (bitv > v) bitv >>= 2;
         while (bitv != 0) begin
            if (v >= root + bitv) begin
               v -= root + bitv;
               root = (root >> 1) + bitv;
            end else begin
               root >>= 1;
            end
            bitv >>= 2;
         end
         return root;
      endfunction

      function void note_item(mpc_pkg::req_data_type d);
         mpc_pkg::rsp_data_type r;
         longint fa[3];
         longint fr[3];
         longint acc_in[3];
         longint rot_in[3];
         longint unsigned sumsq, mag, delta, interval, bpm;
         acc_in = '{d.acc_x, d.acc_y, d.acc_z};
         rot_in = '{d.rot_x, d.rot_y, d.rot_z};
         sumsq = 0;
         for (int i = 0; i < 3; i++) begin
            acc_state[i] = lowpass(acc_state[i], acc_in[i]);
            rot_state[i] = lowpass(rot_state[i], rot_in[i]);
            fa[i] = counts(acc_state[i]);
            fr[i] = counts(rot_state[i]);
            sumsq += fa[i] * fa[i];
         end
         mag = sqrt_floor(sumsq);
         delta = (mag >= prev_mag) ? mag - prev_mag : prev_mag - mag;
         prev_mag = mag;
         activity_q16 = ((activity_q16 * 58982) >> 16) + (delta << 16);
         if (activity_q16 > 64'hF_FFFF_FFFF) activity_q16 = 64'hF_FFFF_FFFF;
         // peak detection on a falling infrared reading
         if (d.pulse_present) begin
            if (d.ir_sample < prev_ir && prev_ir > 0) begin
               peaks++;
               if (last_peak > 0 && rate_count < mpc_pkg::PEAK_LIMIT &&
                   d.time_us > last_peak) begin
                  interval = d.time_us - last_peak;
                  bpm = 60000000 / interval;
                  if (bpm >= rate_lo && bpm <= rate_hi) begin
                     rate = ((rate * 3 + bpm) / 4) & 8'hFF;
                     rate_count++;
                  end
               end
               last_peak = d.time_us;
            end
            prev_ir = d.ir_sample;
         end
         r.fil_acc_x = 16'(fa[0]);
         r.fil_acc_y = 16'(fa[1]);
         r.fil_acc_z = 16'(fa[2]);
         r.fil_rot_x = 16'(fr[0]);
         r.fil_rot_y = 16'(fr[1]);
         r.fil_rot_z = 16'(fr[2]);
         r.acc_magnitude = 16'(mag);
         r.activity = 20'(activity_q16 >> 16);
         r.beat_rate = d.pulse_present ? rate[7:0] : 8'd0;
         r.beat_rate_valid = d.pulse_present && rate_count >= 3;
         r.time_out = d.time_us;
         expected_q.push_back(r);
      endfunction

      function void compare(string name, longint unsigned exp_v, longint unsigned act_v);
         if (exp_v != act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_item(mpc_pkg::rsp_data_type a);
         mpc_pkg::rsp_data_type e;
         if (expected_q.size() == 0) begin
            $error("result item with nothing expected");
            errors++;
            return;
         end
         e = expected_q.pop_front();
         checked++;
         compare("fil_acc_x", e.fil_acc_x, a.fil_acc_x);
         compare("fil_acc_y", e.fil_acc_y, a.fil_acc_y);
         compare("fil_acc_z", e.fil_acc_z, a.fil_acc_z);
         compare("fil_rot_x", e.fil_rot_x, a.fil_rot_x);
         compare("fil_rot_y", e.fil_rot_y, a.fil_rot_y);
         compare("fil_rot_z", e.fil_rot_z, a.fil_rot_z);
         compare("acc_magnitude", e.acc_magnitude, a.acc_magnitude);
         compare("activity", e.activity, a.activity);
         compare("beat_rate", e.beat_rate, a.beat_rate);
         compare("beat_rate_valid", e.beat_rate_valid, a.beat_rate_valid);
         compare("time_out", e.time_out, a.time_out);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [mpc_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [mpc_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   mpc_req_if req_chan ();
   mpc_rsp_if rsp_chan ();

   motion_and_pulse_conditioning i_dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_OFF_CYCLES = 300;
   // index past the last register, must be ignored
   localparam logic [mpc_pkg::CSR_INDEX_W-1:0] REG_UNUSED = 2'd3;

   conditioning_scoreboard sb = new();
   bit no_idle = 1'b0;
   bit hold_off_req = 1'b0;
   int idle_cycles = 0;
   longint unsigned train_time = 64'd1000;
   bit train_high = 1'b0;

   always #5 clock = ~clock;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.data = '0;
      rsp_chan.ready = 1'b0;
   end

   // Monitor both channels and run the watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) sb.note_item(req_chan.data);
         if (rsp_chan.valid && rsp_chan.ready) sb.check_item(rsp_chan.data);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Receiver: random stalls, one long hold-off when requested
   initial begin
      int cnt;
      @(negedge clock);
      forever begin
         if (hold_off_req) begin
            rsp_chan.ready <= 1'b0;
            for (cnt = 0; cnt < HOLD_OFF_CYCLES; cnt++) @(negedge clock);
            hold_off_req = 1'b0;
         end else if (no_idle || $urandom_range(0, 3) != 0) begin
            rsp_chan.ready <= 1'b1;
            @(negedge clock);
         end else begin
            rsp_chan.ready <= 1'b0;
            cnt = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 50);
            repeat (cnt) @(negedge clock);
         end
      end
   end

   // valid stays high after an accept; req_idle, or a gap in the next call, lowers it
   task automatic send_item(mpc_pkg::req_data_type d);
      int gap;
      if (!no_idle && $urandom_range(0, 2) == 0) begin
         gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 60);
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data <= d;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic req_idle();
      req_chan.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_reg(logic [mpc_pkg::CSR_INDEX_W-1:0] idx,
                            logic [mpc_pkg::CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Let the block drain before touching its registers
   task automatic wait_drained();
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   function automatic mpc_pkg::req_data_type motion(mpc_pkg::req_data_type d);
      d.acc_x = 16'($urandom);
      d.acc_y = 16'($urandom);
      d.acc_z = 16'($urandom);
      d.rot_x = 16'($urandom);
      d.rot_y = 16'($urandom);
      d.rot_z = 16'($urandom);
      if ($urandom_range(0, 7) == 0) begin
         d.acc_x = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         d.acc_y = d.acc_x;
         d.acc_z = d.acc_x;
      end
      return d;
   endfunction

   // Mostly well-formed pulse trains; the rest noise and broken sequences
   function automatic mpc_pkg::req_data_type random_item();
      mpc_pkg::req_data_type d;
      d = motion('0);
      if ($urandom_range(0, 9) < 8) begin
         train_time += $urandom_range(150000, 800000);
         if ($urandom_range(0, 19) == 0) train_time -= $urandom_range(0, 2000000);
         train_time &= 64'hFFFF_FFFF_FFFF;
         train_high = !train_high;
         d.time_us = 48'(train_time);
         d.pulse_present = 1'b1;
         d.ir_sample = train_high ? 18'($urandom_range(100000, 262143)) :
                                    18'($urandom_range(0, 99999));
      end else begin
         d.time_us = 48'({$urandom, $urandom});
         if ($urandom_range(0, 3) == 0) d.time_us = 48'd0;
         d.pulse_present = 1'($urandom);
         d.ir_sample = 18'($urandom);
      end
      return d;
   endfunction

   task automatic directed_items();
      mpc_pkg::req_data_type d;
      d = '0;
      send_item(d);
      d.acc_x = 16'sh7FFF; d.acc_y = 16'sh7FFF; d.acc_z = 16'sh7FFF;
      d.rot_x = 16'sh7FFF; d.rot_y = 16'sh7FFF; d.rot_z = 16'sh7FFF;
      d.time_us = 48'hFFFF_FFFF_FFFF;
      send_item(d);
      d.acc_x = 16'sh8000; d.acc_y = 16'sh8000; d.acc_z = 16'sh8000;
      d.rot_x = 16'sh8000; d.rot_y = 16'sh8000; d.rot_z = 16'sh8000;
      send_item(d);
      // pulse: the first peak comes at time zero, so the next one has no earlier time
      d = '0;
      d.pulse_present = 1'b1;
      d.time_us = 48'd100;     d.ir_sample = 18'h3FFFF; send_item(d);
      d.time_us = 48'd0;       d.ir_sample = 18'd5;     send_item(d);
      d.time_us = 48'd500000;  d.ir_sample = 18'd9000;  send_item(d);
      d.time_us = 48'd1000000; d.ir_sample = 18'd10;    send_item(d);
      // accepted rates, a gap without pulse, then time running backwards
      d.time_us = 48'd1200000; d.ir_sample = 18'd9000;  send_item(d);
      d.time_us = 48'd1750000; d.ir_sample = 18'd100;   send_item(d);
      d.pulse_present = 1'b0;  d.ir_sample = 18'd0;     send_item(d);
      d.pulse_present = 1'b1;
      d.time_us = 48'd1800000; d.ir_sample = 18'd9000;  send_item(d);
      d.time_us = 48'd1700000; d.ir_sample = 18'd100;   send_item(d);
      d.time_us = 48'd1900000; d.ir_sample = 18'd9000;  send_item(d);
      d.time_us = 48'd1900001; d.ir_sample = 18'd100;   send_item(d);
      for (int i = 0; i < 8; i++) begin
         d.time_us += 48'd400000;
         d.ir_sample = (i % 2 == 0) ? 18'd9000 : 18'd100;
         send_item(d);
      end
   endtask

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++) send_item(random_item());
      req_idle();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      directed_items();
      random_phase(160);
      wait_drained();

      write_reg(mpc_pkg::REG_FILTER_ALPHA, 16'hFFFF);
      write_reg(mpc_pkg::REG_RATE_MIN, 16'd1);
      write_reg(mpc_pkg::REG_RATE_MAX, 16'd255);
      hold_off_req = 1'b1;
      random_phase(160);
      wait_drained();

      // alpha zero freezes the filters; inverted rate range
      write_reg(mpc_pkg::REG_FILTER_ALPHA, 16'd0);
      write_reg(mpc_pkg::REG_RATE_MIN, 16'd255);
      write_reg(mpc_pkg::REG_RATE_MAX, 16'd1);
      no_idle = 1'b1;
      random_phase(160);
      no_idle = 1'b0;
      wait_drained();

      write_reg(mpc_pkg::REG_FILTER_ALPHA, 16'd1);
      write_reg(mpc_pkg::REG_RATE_MIN, 16'd40);
      write_reg(mpc_pkg::REG_RATE_MAX, 16'd200);
      write_reg(REG_UNUSED, 16'hFFFF);
      random_phase(160);
      wait_drained();

      write_reg(mpc_pkg::REG_FILTER_ALPHA, 16'd32768);
      write_reg(mpc_pkg::REG_RATE_MIN, 16'h5A3C);
      write_reg(mpc_pkg::REG_RATE_MAX, 16'hA5B4);
      random_phase(160);
      wait_drained();

      $display("checked %0d result items over five register settings, %0d pulse peaks seen",
               sb.checked, sb.peaks);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
